// ----- hw/rtl/deq_pkg.sv -----
// shared operation and status codes for the double-ended queue
package deq_pkg;

    // operation requested by one input transaction
    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_REVERSE    = 3'd4,
        MODE_PEEK       = 3'd5
    } t_mode;

    // outcome reported with each result transaction
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned COUNT_W = 5;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// double-ended queue: ring buffer with head index, fill count and reversed-order flag
// path: a taken input transaction passes the read-stage registers, then the output register
// throughput: one transaction per cycle; the two-port register-file read of both ends
// and the output register set the pipeline, stalls back up through the input stall
// reset: synchronous active low; clears head, count, order flag and pipeline valids,
// the entry storage is not cleared and needs no clearing pass
module double_ended_queue #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned VALUE_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_mode,
    input  logic [deq_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [deq_pkg::VALUE_W-1:0]   o_front_value,
    output logic [deq_pkg::VALUE_W-1:0]   o_back_value,
    output logic [deq_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty,
    output logic [1:0]                    o_status
);

    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;

    // entry storage
    logic [VALUE_BITS-1:0] r_mem [DEPTH];

    // deque state
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rev, n_rev;

    // read stage
    logic                  r_s1_valid;
    logic [CNT_W-1:0]      r_s1_count;
    logic                  r_s1_rev;
    deq_pkg::t_status      r_s1_status;
    logic [VALUE_BITS-1:0] r_s1_lo;
    logic [VALUE_BITS-1:0] r_s1_hi;
    logic                  r_s1_fwd_lo;
    logic                  r_s1_fwd_hi;
    logic [VALUE_BITS-1:0] r_s1_wdata;

    // output stage
    logic                        r_out_valid;
    logic [deq_pkg::VALUE_W-1:0] r_front;
    logic [deq_pkg::VALUE_W-1:0] r_back;
    logic [deq_pkg::COUNT_W-1:0] r_cnt_out;
    logic                        r_empty_out;
    deq_pkg::t_status            r_status_out;

    deq_pkg::t_mode        w_mode;
    deq_pkg::t_status      w_status;
    logic                  w_in_accept;
    logic                  w_s1_advance;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_push_low;
    logic                  w_pop_low;
    logic [IDX_W-1:0]      w_head_dec;
    logic [IDX_W-1:0]      w_head_inc;
    logic [SUM_W-1:0]      w_tail_sum;
    logic [IDX_W-1:0]      w_tail_pos;
    logic [SUM_W-1:0]      w_high_sum;
    logic [IDX_W-1:0]      w_high_pos;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [VALUE_BITS-1:0] w_wdata;
    logic [VALUE_BITS-1:0] w_lo_val;
    logic [VALUE_BITS-1:0] w_hi_val;

    // handshakes
    assign w_s1_advance = !r_out_valid || !i_out_stall;
    assign o_in_stall   = r_s1_valid && !w_s1_advance;
    assign w_in_accept  = i_in_valid && !o_in_stall;

    // ring positions around the current state
    assign w_mode     = deq_pkg::t_mode'(i_mode);
    assign w_wdata    = i_value[VALUE_BITS-1:0];
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_push_low = (w_mode == deq_pkg::MODE_PUSH_FRONT) != r_rev;
    assign w_pop_low  = (w_mode == deq_pkg::MODE_POP_FRONT) != r_rev;
    assign w_head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - IDX_W'(1);
    assign w_head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
    assign w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail_pos = (w_tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(w_tail_sum - SUM_W'(DEPTH))
                                                      : IDX_W'(w_tail_sum);

    // next state and status for the offered transaction
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        w_status = deq_pkg::STATUS_DONE;
        w_we     = 1'b0;
        w_waddr  = w_tail_pos;
        unique case (w_mode)
            deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
                if (w_full) begin
                    w_status = deq_pkg::STATUS_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (w_push_low) begin
                        n_head  = w_head_dec;
                        w_waddr = w_head_dec;
                    end
                end
            end
            deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    w_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (w_pop_low) begin
                        n_head = w_head_inc;
                    end
                end
            end
            deq_pkg::MODE_REVERSE: begin
                if (w_empty) begin
                    w_status = deq_pkg::STATUS_EMPTY;
                end else begin
                    n_rev = !r_rev;
                end
            end
            default: begin
            end
        endcase
    end

    // high end after the step, only meaningful when not empty
    assign w_high_sum = SUM_W'(n_head) + SUM_W'(n_count - CNT_W'(1));
    assign w_high_pos = (w_high_sum >= SUM_W'(DEPTH)) ? IDX_W'(w_high_sum - SUM_W'(DEPTH))
                                                      : IDX_W'(w_high_sum);

    // storage write and read of both ends
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            if (w_we) begin
                r_mem[w_waddr] <= w_wdata;
            end
            r_s1_lo <= r_mem[n_head];
            r_s1_hi <= r_mem[w_high_pos];
        end
    end

    // state and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_rev   <= n_rev;
            end
            if (w_s1_advance) begin
                r_s1_valid <= w_in_accept;
            end else if (w_in_accept) begin
                r_s1_valid <= 1'b1;
            end
            if (w_s1_advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // read stage payload, with forwarding of a same-cycle write
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_count  <= n_count;
            r_s1_rev    <= n_rev;
            r_s1_status <= w_status;
            r_s1_wdata  <= w_wdata;
            r_s1_fwd_lo <= w_we && (w_waddr == n_head);
            r_s1_fwd_hi <= w_we && (w_waddr == w_high_pos);
        end
    end

    // pick front and back, zero when empty
    assign w_lo_val = r_s1_fwd_lo ? r_s1_wdata : r_s1_lo;
    assign w_hi_val = r_s1_fwd_hi ? r_s1_wdata : r_s1_hi;

    always_ff @(posedge i_clk) begin
        if (w_s1_advance && r_s1_valid) begin
            if (r_s1_count == '0) begin
                r_front <= '0;
                r_back  <= '0;
            end else begin
                r_front <= deq_pkg::VALUE_W'(r_s1_rev ? w_hi_val : w_lo_val);
                r_back  <= deq_pkg::VALUE_W'(r_s1_rev ? w_lo_val : w_hi_val);
            end
            r_cnt_out    <= deq_pkg::COUNT_W'(r_s1_count);
            r_empty_out  <= (r_s1_count == '0);
            r_status_out <= r_s1_status;
        end
    end

    // result transaction ports
    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_count       = r_cnt_out;
    assign o_is_empty    = r_empty_out;
    assign o_status      = r_status_out;

endmodule
